[rtl/core/ljpf_pkg.sv]
// Package for the Lennard-Jones pair force core: widths, register indexes and
// the sideband word that travels down the cell chains. No dependencies.
package ljpf_pkg;

    // Field widths of the ports.
    localparam int POS_WIDTH    = 32;
    localparam int RESULT_WIDTH = 48;
    localparam int CFG_W        = 32;
    localparam int IDX_W        = 3;

    // Displacement and squared distance widths.
    localparam int D_W      = POS_WIDTH + 2;
    localparam int DMAG_W   = POS_WIDTH + 1;
    localparam int SQ_W     = 2 * DMAG_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int RAD_SHIFT = 4;
    localparam int RAD_W    = SUM_W + RAD_SHIFT;

    // Square root chain: one root bit per cell.
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SQRT_CELLS = ROOT_W;
    localparam int SQ_REM_W   = ROOT_W + 3;

    // Distance r after the shift is added.
    localparam int R_W = ((ROOT_W > CFG_W) ? ROOT_W : CFG_W) + 1;

    // Q32.32 magnitudes and the divider chain: one quotient bit per cell.
    localparam int Q_W       = 64;
    localparam int HALF_W    = Q_W / 2;
    localparam int DIV_CELLS = Q_W;
    localparam int IR_SHIFT  = 56;
    localparam int DMAG_SHIFT = 10;
    localparam int E_SHIFT   = 8;
    localparam int OUT_SHIFT = 8;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_SIGMA     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_EPSILON   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SHIFT     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_THIRD_LAW = 3'd3;
    localparam logic [IDX_W-1:0] CFG_POT_EN    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_PRESS_EN  = 3'd5;

    // Per-pair data that rides along with the arithmetic.
    typedef struct packed {
        logic [2:0][DMAG_W-1:0] dmag;
        logic [2:0]             dneg;
        logic                   rzero;
    } t_side;

endpackage

[rtl/core/ljpf_sqrt_cell.sv]
// One cell of the square root chain: settles one root bit per cycle.
// Depends on ljpf_pkg.
module ljpf_sqrt_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [ljpf_pkg::RAD_W-1:0]    i_rad,
    input  logic [ljpf_pkg::SQ_REM_W-1:0] i_rem,
    input  logic [ljpf_pkg::ROOT_W-1:0]   i_root,
    input  ljpf_pkg::t_side               i_side,
    output logic                          o_vld,
    output logic [ljpf_pkg::RAD_W-1:0]    o_rad,
    output logic [ljpf_pkg::SQ_REM_W-1:0] o_rem,
    output logic [ljpf_pkg::ROOT_W-1:0]   o_root,
    output ljpf_pkg::t_side               o_side
);
    import ljpf_pkg::*;

    logic [SQ_REM_W-1:0] n_shift;
    logic [SQ_REM_W-1:0] n_trial;
    logic                n_take;
    logic                r_vld;
    logic [RAD_W-1:0]    r_rad;
    logic [SQ_REM_W-1:0] r_rem;
    logic [ROOT_W-1:0]   r_root;
    t_side               r_side;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
        n_shift = {i_rem[SQ_REM_W-3:0], i_rad[RAD_W-1 -: 2]};
        n_trial = SQ_REM_W'({i_root, 2'b01});
        n_take  = (n_shift >= n_trial);
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // Payload hand-off to the next cell.
    always_ff @(posedge i_clk) begin
        r_rad  <= i_rad << 2;
        r_rem  <= n_take ? (n_shift - n_trial) : n_shift;
        r_root <= {i_root[ROOT_W-2:0], n_take};
        r_side <= i_side;
    end

    assign o_vld  = r_vld;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;

    // The partial remainder never exceeds twice the partial root.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (o_rem <= SQ_REM_W'({o_root, 1'b0})))
        else $error("sqrt cell remainder out of range");

endmodule

[rtl/core/ljpf_div_cell.sv]
// One cell of the divider chain: one quotient bit per cycle for the two
// divisions sigma/r and 1/r that share the divisor. Depends on ljpf_pkg.
module ljpf_div_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic [ljpf_pkg::Q_W-1:0] i_num_t,
    input  logic [ljpf_pkg::Q_W-1:0] i_num_i,
    input  logic [ljpf_pkg::R_W-1:0] i_rem_t,
    input  logic [ljpf_pkg::R_W-1:0] i_rem_i,
    input  logic [ljpf_pkg::Q_W-1:0] i_quo_t,
    input  logic [ljpf_pkg::Q_W-1:0] i_quo_i,
    input  logic [ljpf_pkg::R_W-1:0] i_den,
    input  ljpf_pkg::t_side          i_side,
    output logic                     o_vld,
    output logic [ljpf_pkg::Q_W-1:0] o_num_t,
    output logic [ljpf_pkg::Q_W-1:0] o_num_i,
    output logic [ljpf_pkg::R_W-1:0] o_rem_t,
    output logic [ljpf_pkg::R_W-1:0] o_rem_i,
    output logic [ljpf_pkg::Q_W-1:0] o_quo_t,
    output logic [ljpf_pkg::Q_W-1:0] o_quo_i,
    output logic [ljpf_pkg::R_W-1:0] o_den,
    output ljpf_pkg::t_side          o_side
);
    import ljpf_pkg::*;

    logic [R_W:0]   n_sh_t;
    logic [R_W:0]   n_sh_i;
    logic [R_W:0]   n_dv;
    logic           n_take_t;
    logic           n_take_i;
    logic           r_vld;
    logic [Q_W-1:0] r_num_t;
    logic [Q_W-1:0] r_num_i;
    logic [R_W-1:0] r_rem_t;
    logic [R_W-1:0] r_rem_i;
    logic [Q_W-1:0] r_quo_t;
    logic [Q_W-1:0] r_quo_i;
    logic [R_W-1:0] r_den;
    t_side          r_side;

    // Restoring step on both lanes.
    always_comb begin
        n_sh_t   = {i_rem_t, i_num_t[Q_W-1]};
        n_sh_i   = {i_rem_i, i_num_i[Q_W-1]};
        n_dv     = {1'b0, i_den};
        n_take_t = (n_sh_t >= n_dv);
        n_take_i = (n_sh_i >= n_dv);
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // Payload hand-off to the next cell.
    always_ff @(posedge i_clk) begin
        r_num_t <= i_num_t << 1;
        r_num_i <= i_num_i << 1;
        r_rem_t <= n_take_t ? R_W'(n_sh_t - n_dv) : n_sh_t[R_W-1:0];
        r_rem_i <= n_take_i ? R_W'(n_sh_i - n_dv) : n_sh_i[R_W-1:0];
        r_quo_t <= {i_quo_t[Q_W-2:0], n_take_t};
        r_quo_i <= {i_quo_i[Q_W-2:0], n_take_i};
        r_den   <= i_den;
        r_side  <= i_side;
    end

    assign o_vld   = r_vld;
    assign o_num_t = r_num_t;
    assign o_num_i = r_num_i;
    assign o_rem_t = r_rem_t;
    assign o_rem_i = r_rem_i;
    assign o_quo_t = r_quo_t;
    assign o_quo_i = r_quo_i;
    assign o_den   = r_den;
    assign o_side  = r_side;

    // With a nonzero divisor both remainders stay below it.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vld && (o_den != '0)) |-> ((o_rem_t < o_den) && (o_rem_i < o_den)))
        else $error("divider cell remainder not below divisor");

endmodule

[rtl/core/ljpf_qmul.sv]
// Saturating Q32.32 multiplier: four registered 32x32 partial products, then
// the sum and the saturation check. Depends on ljpf_pkg.
module ljpf_qmul (
    input  logic                     i_clk,
    input  logic [ljpf_pkg::Q_W-1:0] i_a,
    input  logic [ljpf_pkg::Q_W-1:0] i_b,
    output logic [ljpf_pkg::Q_W-1:0] o_p,
    output logic                     o_sat
);
    import ljpf_pkg::*;

    logic [Q_W-1:0]   r_ll;
    logic [Q_W-1:0]   r_lh;
    logic [Q_W-1:0]   r_hl;
    logic [Q_W-1:0]   r_hh;
    logic [2*Q_W-1:0] n_full;

    // Partial products.
    always_ff @(posedge i_clk) begin
        r_ll <= Q_W'(i_a[HALF_W-1:0]) * Q_W'(i_b[HALF_W-1:0]);
        r_lh <= Q_W'(i_a[HALF_W-1:0]) * Q_W'(i_b[Q_W-1:HALF_W]);
        r_hl <= Q_W'(i_a[Q_W-1:HALF_W]) * Q_W'(i_b[HALF_W-1:0]);
        r_hh <= Q_W'(i_a[Q_W-1:HALF_W]) * Q_W'(i_b[Q_W-1:HALF_W]);
    end

    // Full product; anything at or above 2^96 saturates.
    always_comb begin
        n_full = (2*Q_W)'(r_ll) + ((2*Q_W)'(r_lh) << HALF_W)
               + ((2*Q_W)'(r_hl) << HALF_W) + {r_hh, {Q_W{1'b0}}};
        o_sat  = |n_full[2*Q_W-1 -: HALF_W];
        o_p    = o_sat ? {Q_W{1'b1}} : n_full[Q_W+HALF_W-1:HALF_W];
    end

endmodule

[rtl/core/lennard_jones_pair_force_core.sv]
// Top level of the Lennard-Jones pair force core: front end, square root
// and divider chains, multiplier pipeline and output saturation.
// Depends on ljpf_pkg, ljpf_sqrt_cell, ljpf_div_cell and ljpf_qmul.
//
// Usage: drive the nine position words and pulse start; a word is taken at
// every rising edge where start is high and busy is low. After reset busy is
// low, so one pair can be taken in every cycle.
// Each result word appears on the result ports for one cycle with o_strobe
// high. Results leave in the order the pairs came in. The receiver cannot
// stall the block; the pipeline never holds. A pair passes through three
// front end stages, the 36-cell square root chain, one stage for the distance
// shift, the 64-cell divider chain (one quotient bit per cell), eight multiply
// steps, each a partial product register and a stage register, with one
// subtract stage, and the output register.
// Configuration words are taken on the cfg channel, which is always ready;
// write them only while no pair is in flight.
// Synchronous reset clears all valid bits, loads the register defaults and
// holds busy high.
module lennard_jones_pair_force_core (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [ljpf_pkg::POS_WIDTH-1:0]    i_first_x,
    input  logic signed [ljpf_pkg::POS_WIDTH-1:0]    i_first_y,
    input  logic signed [ljpf_pkg::POS_WIDTH-1:0]    i_first_z,
    input  logic signed [ljpf_pkg::POS_WIDTH-1:0]    i_second_x,
    input  logic signed [ljpf_pkg::POS_WIDTH-1:0]    i_second_y,
    input  logic signed [ljpf_pkg::POS_WIDTH-1:0]    i_second_z,
    input  logic signed [ljpf_pkg::POS_WIDTH-1:0]    i_offset_x,
    input  logic signed [ljpf_pkg::POS_WIDTH-1:0]    i_offset_y,
    input  logic signed [ljpf_pkg::POS_WIDTH-1:0]    i_offset_z,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [ljpf_pkg::IDX_W-1:0]               i_cfg_index,
    input  logic [ljpf_pkg::CFG_W-1:0]               i_cfg_data,
    output logic                                     o_strobe,
    output logic signed [ljpf_pkg::RESULT_WIDTH-1:0] o_force_x,
    output logic signed [ljpf_pkg::RESULT_WIDTH-1:0] o_force_y,
    output logic signed [ljpf_pkg::RESULT_WIDTH-1:0] o_force_z,
    output logic signed [ljpf_pkg::RESULT_WIDTH-1:0] o_half_potential,
    output logic signed [ljpf_pkg::RESULT_WIDTH-1:0] o_half_pressure,
    output logic                                     o_partner_applies,
    output logic                                     o_overflow
);
    import ljpf_pkg::*;

    localparam int POST = 17;
    localparam int LAT  = 3 + SQRT_CELLS + 1 + DIV_CELLS + POST + 1;
    localparam logic [Q_W-1:0] MAXP = (Q_W'(1) << (RESULT_WIDTH-1)) - Q_W'(1);
    localparam int NMUL = 12;

    typedef struct packed {
        t_side                side;
        logic [Q_W-1:0]       t;
        logic [Q_W-1:0]       ir;
        logic [Q_W-1:0]       q;
        logic [Q_W-1:0]       qq;
        logic [Q_W-1:0]       s6;
        logic [Q_W-1:0]       s12;
        logic [Q_W-1:0]       amag;
        logic [Q_W-1:0]       pmag;
        logic [Q_W-1:0]       w;
        logic [Q_W-1:0]       hpm;
        logic [Q_W-1:0]       hrm;
        logic [Q_W-1:0]       f1;
        logic [Q_W-1:0]       f;
        logic [2:0][Q_W-1:0]  fm;
        logic                 aneg;
        logic                 pneg;
        logic                 sat;
        logic                 psat;
        logic                 rsat;
    } t_carry;

    // Clamp a Q32.32 magnitude with sign into the result format.
    function automatic logic [RESULT_WIDTH:0] f_to_out(input logic neg,
                                                       input logic [Q_W-1:0] mag32);
        logic [Q_W-1:0] mag;
        logic [Q_W-1:0] lim;
        logic           s;
        mag = mag32 >> OUT_SHIFT;
        lim = neg ? (MAXP + Q_W'(1)) : MAXP;
        s   = (mag > lim);
        if (s) begin
            mag = lim;
        end
        return {s, (neg ? RESULT_WIDTH'(Q_W'(0) - mag) : mag[RESULT_WIDTH-1:0])};
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0] r_sigma;
    logic [CFG_W-1:0] r_epsilon;
    logic [CFG_W-1:0] r_shift;
    logic             r_third;
    logic             r_pot_en;
    logic             r_press_en;
    logic             r_busy;
    logic             n_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma    <= CFG_W'(32'd16777216);
            r_epsilon  <= CFG_W'(32'd16777216);
            r_shift    <= '0;
            r_third    <= 1'b1;
            r_pot_en   <= 1'b1;
            r_press_en <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SIGMA:     r_sigma    <= i_cfg_data;
                CFG_EPSILON:   r_epsilon  <= i_cfg_data;
                CFG_SHIFT:     r_shift    <= i_cfg_data;
                CFG_THIRD_LAW: r_third    <= i_cfg_data[0];
                CFG_POT_EN:    r_pot_en   <= i_cfg_data[0];
                CFG_PRESS_EN:  r_press_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Busy is held only through reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign n_accept = start && !r_busy;

    // Front end: displacement, squares and their sum.
    logic signed [D_W-1:0]  n_d [3];
    logic signed [D_W-1:0]  r_d [3];
    logic [D_W-1:0]         n_abs [3];
    logic [SQ_W-1:0]        r_sq [3];
    logic [DMAG_W-1:0]      r_dmag [3];
    logic [2:0]             r_dneg;
    logic [SUM_W-1:0]       r_sum;
    t_side                  r_side2;
    logic                   r_v0;
    logic                   r_v1;
    logic                   r_v2;

    always_comb begin
        n_d[0] = D_W'(i_second_x) + D_W'(i_offset_x) - D_W'(i_first_x);
        n_d[1] = D_W'(i_second_y) + D_W'(i_offset_y) - D_W'(i_first_y);
        n_d[2] = D_W'(i_second_z) + D_W'(i_offset_z) - D_W'(i_first_z);
        for (int i = 0; i < 3; i++) begin
            n_abs[i] = r_d[i][D_W-1] ? D_W'(-r_d[i]) : D_W'(r_d[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= n_accept;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_d[i]    <= n_d[i];
            r_dmag[i] <= n_abs[i][DMAG_W-1:0];
            r_dneg[i] <= r_d[i][D_W-1];
            r_sq[i]   <= SQ_W'(n_abs[i][DMAG_W-1:0]) * SQ_W'(n_abs[i][DMAG_W-1:0]);
            r_side2.dmag[i] <= r_dmag[i];
        end
        r_side2.dneg  <= r_dneg;
        r_side2.rzero <= 1'b0;
        r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    end

    // Square root chain.
    logic                sq_vld  [SQRT_CELLS+1];
    logic [RAD_W-1:0]    sq_rad  [SQRT_CELLS+1];
    logic [SQ_REM_W-1:0] sq_rem  [SQRT_CELLS+1];
    logic [ROOT_W-1:0]   sq_root [SQRT_CELLS+1];
    t_side               sq_side [SQRT_CELLS+1];

    assign sq_vld[0]  = r_v2;
    assign sq_rad[0]  = RAD_W'(r_sum) << RAD_SHIFT;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = r_side2;

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        ljpf_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (sq_vld[g]),
            .i_rad   (sq_rad[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_side  (sq_side[g]),
            .o_vld   (sq_vld[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    // Distance with shift, and the zero distance flag.
    logic [R_W-1:0] r_r;
    logic [R_W-1:0] n_r;
    t_side          n_side3;
    t_side          r_side3;
    logic           r_v3;

    assign n_r = R_W'(sq_root[SQRT_CELLS]) + R_W'(r_shift);

    always_comb begin
        n_side3       = sq_side[SQRT_CELLS];
        n_side3.rzero = (n_r == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= sq_vld[SQRT_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_r     <= n_r;
        r_side3 <= n_side3;
    end

    // Divider chain.
    logic           dv_vld   [DIV_CELLS+1];
    logic [Q_W-1:0] dv_num_t [DIV_CELLS+1];
    logic [Q_W-1:0] dv_num_i [DIV_CELLS+1];
    logic [R_W-1:0] dv_rem_t [DIV_CELLS+1];
    logic [R_W-1:0] dv_rem_i [DIV_CELLS+1];
    logic [Q_W-1:0] dv_quo_t [DIV_CELLS+1];
    logic [Q_W-1:0] dv_quo_i [DIV_CELLS+1];
    logic [R_W-1:0] dv_den   [DIV_CELLS+1];
    t_side          dv_side  [DIV_CELLS+1];

    assign dv_vld[0]   = r_v3;
    assign dv_num_t[0] = Q_W'(r_sigma) << HALF_W;
    assign dv_num_i[0] = Q_W'(1) << IR_SHIFT;
    assign dv_rem_t[0] = '0;
    assign dv_rem_i[0] = '0;
    assign dv_quo_t[0] = '0;
    assign dv_quo_i[0] = '0;
    assign dv_den[0]   = r_r;
    assign dv_side[0]  = r_side3;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        ljpf_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (dv_vld[g]),
            .i_num_t (dv_num_t[g]),
            .i_num_i (dv_num_i[g]),
            .i_rem_t (dv_rem_t[g]),
            .i_rem_i (dv_rem_i[g]),
            .i_quo_t (dv_quo_t[g]),
            .i_quo_i (dv_quo_i[g]),
            .i_den   (dv_den[g]),
            .i_side  (dv_side[g]),
            .o_vld   (dv_vld[g+1]),
            .o_num_t (dv_num_t[g+1]),
            .o_num_i (dv_num_i[g+1]),
            .o_rem_t (dv_rem_t[g+1]),
            .o_rem_i (dv_rem_i[g+1]),
            .o_quo_t (dv_quo_t[g+1]),
            .o_quo_i (dv_quo_i[g+1]),
            .o_den   (dv_den[g+1]),
            .o_side  (dv_side[g+1])
        );
    end

    // Multiplier pipeline.
    t_carry         c0;
    t_carry         r_c [1:POST];
    t_carry         n_c [1:POST];
    logic           r_vc [1:POST];
    logic [Q_W-1:0] mq_a   [NMUL];
    logic [Q_W-1:0] mq_b   [NMUL];
    logic [Q_W-1:0] mq_p   [NMUL];
    logic           mq_sat [NMUL];
    logic [Q_W-1:0] n_e;
    logic [Q_W-1:0] n_twos;
    logic           n_tsat;

    always_comb begin
        c0      = '0;
        c0.side = dv_side[DIV_CELLS];
        c0.t    = dv_quo_t[DIV_CELLS];
        c0.ir   = dv_quo_i[DIV_CELLS];
    end

    // Energy scale and the doubled repulsive term.
    always_comb begin
        n_e    = Q_W'(r_epsilon) << E_SHIFT;
        n_tsat = r_c[8].s12[Q_W-1];
        n_twos = n_tsat ? {Q_W{1'b1}} : (r_c[8].s12 << 1);
    end

    // Multiplier operands by step.
    always_comb begin
        mq_a[0] = c0.t;            mq_b[0] = c0.t;
        mq_a[1] = r_c[2].q;        mq_b[1] = r_c[2].q;
        mq_a[2] = r_c[4].qq;       mq_b[2] = r_c[4].q;
        mq_a[3] = r_c[6].s6;       mq_b[3] = r_c[6].s6;
        mq_a[4] = (n_e << 4) + (n_e << 3);
        mq_b[4] = r_c[9].amag;
        mq_a[5] = n_e << 1;        mq_b[5] = r_c[9].pmag;
        mq_a[6] = (n_e << 3) + (n_e << 2);
        mq_b[6] = r_c[9].amag;
        mq_a[7] = r_c[11].w;       mq_b[7] = r_c[11].ir;
        mq_a[8] = r_c[13].f1;      mq_b[8] = r_c[13].ir;
        for (int i = 0; i < 3; i++) begin
            mq_a[9+i] = Q_W'(r_c[15].side.dmag[i]) << DMAG_SHIFT;
            mq_b[9+i] = r_c[15].f;
        end
    end

    for (genvar g = 0; g < NMUL; g++) begin : g_mul
        ljpf_qmul u_mul (
            .i_clk (i_clk),
            .i_a   (mq_a[g]),
            .i_b   (mq_b[g]),
            .o_p   (mq_p[g]),
            .o_sat (mq_sat[g])
        );
    end

    // Stage contents: pass along, then drop in each step's results.
    always_comb begin
        n_c[1] = c0;
        for (int k = 2; k <= POST; k++) begin
            n_c[k] = r_c[k-1];
        end
        n_c[2].q    = mq_p[0];
        n_c[2].sat  = r_c[1].sat | mq_sat[0];
        n_c[4].qq   = mq_p[1];
        n_c[4].sat  = r_c[3].sat | mq_sat[1];
        n_c[6].s6   = mq_p[2];
        n_c[6].sat  = r_c[5].sat | mq_sat[2];
        n_c[8].s12  = mq_p[3];
        n_c[8].sat  = r_c[7].sat | mq_sat[3];
        n_c[9].aneg = (n_twos < r_c[8].s6);
        n_c[9].amag = (n_twos < r_c[8].s6) ? (r_c[8].s6 - n_twos) : (n_twos - r_c[8].s6);
        n_c[9].pneg = (r_c[8].s12 < r_c[8].s6);
        n_c[9].pmag = (r_c[8].s12 < r_c[8].s6) ? (r_c[8].s6 - r_c[8].s12)
                                               : (r_c[8].s12 - r_c[8].s6);
        n_c[9].sat  = r_c[8].sat | n_tsat;
        n_c[11].w   = mq_p[4];
        n_c[11].sat = r_c[10].sat | mq_sat[4];
        n_c[11].hpm = mq_p[5];
        n_c[11].psat = mq_sat[5];
        n_c[11].hrm = mq_p[6];
        n_c[11].rsat = mq_sat[6];
        n_c[13].f1  = mq_p[7];
        n_c[13].sat = r_c[12].sat | mq_sat[7];
        n_c[15].f   = mq_p[8];
        n_c[15].sat = r_c[14].sat | mq_sat[8];
        n_c[17].sat = r_c[16].sat | mq_sat[9] | mq_sat[10] | mq_sat[11];
        for (int i = 0; i < 3; i++) begin
            n_c[17].fm[i] = mq_p[9+i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= POST; k++) begin
                r_vc[k] <= 1'b0;
            end
        end else begin
            r_vc[1] <= dv_vld[DIV_CELLS];
            for (int k = 2; k <= POST; k++) begin
                r_vc[k] <= r_vc[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= POST; k++) begin
            r_c[k] <= n_c[k];
        end
    end

    // Output formatting, the zero distance case and the overflow flag.
    logic [RESULT_WIDTH:0]   n_fo [3];
    logic [RESULT_WIDTH:0]   n_po;
    logic [RESULT_WIDTH:0]   n_ro;
    logic [RESULT_WIDTH-1:0] n_force [3];
    logic [RESULT_WIDTH-1:0] n_hp;
    logic [RESULT_WIDTH-1:0] n_hr;
    logic                    n_ovf;
    logic                    r_strobe;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_fo[i] = f_to_out(!(r_c[POST].side.dneg[i] ^ r_c[POST].aneg), r_c[POST].fm[i]);
        end
        n_po = f_to_out(r_c[POST].pneg, r_c[POST].hpm);
        n_ro = f_to_out(r_c[POST].aneg, r_c[POST].hrm);
        if (r_c[POST].side.rzero) begin
            for (int i = 0; i < 3; i++) begin
                n_force[i] = '0;
            end
            n_hp  = r_pot_en ? MAXP[RESULT_WIDTH-1:0] : '0;
            n_hr  = r_press_en ? MAXP[RESULT_WIDTH-1:0] : '0;
            n_ovf = 1'b1;
        end else begin
            for (int i = 0; i < 3; i++) begin
                n_force[i] = n_fo[i][RESULT_WIDTH-1:0];
            end
            n_hp  = r_pot_en ? n_po[RESULT_WIDTH-1:0] : '0;
            n_hr  = r_press_en ? n_ro[RESULT_WIDTH-1:0] : '0;
            n_ovf = r_c[POST].sat | n_fo[0][RESULT_WIDTH] | n_fo[1][RESULT_WIDTH]
                  | n_fo[2][RESULT_WIDTH]
                  | (r_pot_en & (r_c[POST].psat | n_po[RESULT_WIDTH]))
                  | (r_press_en & (r_c[POST].rsat | n_ro[RESULT_WIDTH]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vc[POST];
        end
    end

    always_ff @(posedge i_clk) begin
        o_force_x         <= n_force[0];
        o_force_y         <= n_force[1];
        o_force_z         <= n_force[2];
        o_half_potential  <= n_hp;
        o_half_pressure   <= n_hr;
        o_partner_applies <= r_third;
        o_overflow        <= n_ovf;
    end

    assign o_strobe = r_strobe;

    // Every result word traces back to a pair taken a fixed time earlier.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result word without a matching accepted pair");

    // No pair can be taken right after a reset cycle.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

endmodule

[dv/tb_lennard_jones_pair_force_core.sv]
// Self-checking testbench for the Lennard-Jones pair force core.
// Depends on ljpf_pkg and lennard_jones_pair_force_core; it predicts every result word itself.
`timescale 1ns / 100ps

module tb_lennard_jones_pair_force_core;
    import ljpf_pkg::*;

    localparam int RW = RESULT_WIDTH;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 140;
    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [63:0] MAX_POS = 64'hFFFF_FFFF_FFFF_FFFF >> (65 - RW);
    localparam logic [31:0] ONE_Q24 = 32'h0100_0000;

    typedef enum logic [1:0] {JOB_PAIR, JOB_CFG, JOB_DRAIN} t_job_kind;

    typedef struct {
        t_job_kind            kind;
        logic [8:0][31:0]     pos;
        logic [IDX_W-1:0]     idx;
        logic [CFG_W-1:0]     data;
    } t_job;

    typedef struct packed {
        logic [2:0][RW-1:0] force_v;
        logic [RW-1:0]      half_pot;
        logic [RW-1:0]      half_press;
        logic               partner;
        logic               ovf;
    } t_lj_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [POS_WIDTH-1:0] pos_drv [9] = '{default: '0};
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic o_strobe;
    logic signed [RW-1:0] o_force_x, o_force_y, o_force_z;
    logic signed [RW-1:0] o_half_potential, o_half_pressure;
    logic o_partner_applies, o_overflow;

    t_job       job_q[$];
    t_lj_result expected_q[$];
    int         err_count = 0;

    // Predictor copy of the register file.
    logic [31:0] m_sigma, m_epsilon, m_shift;
    logic        m_third_law, m_pot_en, m_press_en;
    logic        m_sat;

    lennard_jones_pair_force_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_first_x(pos_drv[0]), .i_first_y(pos_drv[1]), .i_first_z(pos_drv[2]),
        .i_second_x(pos_drv[3]), .i_second_y(pos_drv[4]), .i_second_z(pos_drv[5]),
        .i_offset_x(pos_drv[6]), .i_offset_y(pos_drv[7]), .i_offset_z(pos_drv[8]),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_force_x(o_force_x), .o_force_y(o_force_y),
        .o_force_z(o_force_z), .o_half_potential(o_half_potential),
        .o_half_pressure(o_half_pressure), .o_partner_applies(o_partner_applies),
        .o_overflow(o_overflow)
    );

    // Clock generation.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Q32.32 product with saturation.
    function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        if (p[127:96] != 0) begin
            m_sat = 1'b1;
            return '1;
        end
        return p[95:32];
    endfunction

    // Q32.32 magnitude to a signed Q.24 output word, clamped.
    function automatic logic [RW-1:0] to_result(input logic neg, input logic [63:0] mag32);
        logic [63:0] mag;
        mag = mag32 >> OUT_SHIFT;
        if (neg) begin
            if (mag > MAX_POS + 1) begin
                mag = MAX_POS + 1;
                m_sat = 1'b1;
            end
            mag = -mag;
            return mag[RW-1:0];
        end
        if (mag > MAX_POS) begin
            mag = MAX_POS;
            m_sat = 1'b1;
        end
        return mag[RW-1:0];
    endfunction

    // Expected result word for one particle pair.
    function automatic t_lj_result lj_pair_force(input logic [8:0][31:0] pos);
        t_lj_result res;
        logic [63:0] d, r, root, cand, t, ir, q, s6, s12, e, twos, amag, pmag, wmag, f;
        logic [63:0] dmag [3];
        logic        dneg [3];
        logic        aneg, pneg;
        logic [127:0] sumsq, rad;
        sumsq = '0;
        m_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            d = 64'(signed'(pos[3+i])) + 64'(signed'(pos[6+i])) - 64'(signed'(pos[i]));
            dneg[i] = d[63];
            dmag[i] = d[63] ? -d : d;
            sumsq += 128'(dmag[i]) * 128'(dmag[i]);
        end
        rad = sumsq << RAD_SHIFT;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= rad)
                root = cand;
        end
        r = root + 64'(m_shift);
        res = '0;
        res.partner = m_third_law;
        // Coincident particles: no force, enabled energy terms pinned at the top.
        if (r == 0) begin
            res.half_pot = m_pot_en ? MAX_POS[RW-1:0] : '0;
            res.half_press = m_press_en ? MAX_POS[RW-1:0] : '0;
            res.ovf = 1'b1;
            return res;
        end
        t = {m_sigma, 32'd0} / r;
        ir = (64'd1 << IR_SHIFT) / r;
        q = q_mul(t, t);
        s6 = q_mul(q_mul(q, q), q);
        s12 = q_mul(s6, s6);
        e = 64'(m_epsilon) << E_SHIFT;
        if (s12 > 64'h7FFF_FFFF_FFFF_FFFF) begin
            twos = '1;
            m_sat = 1'b1;
        end else begin
            twos = s12 << 1;
        end
        aneg = twos < s6;
        amag = aneg ? s6 - twos : twos - s6;
        wmag = q_mul(24 * e, amag);
        f = q_mul(q_mul(wmag, ir), ir);
        for (int i = 0; i < 3; i++)
            res.force_v[i] = to_result(!(dneg[i] ^ aneg), q_mul(dmag[i] << DMAG_SHIFT, f));
        if (m_pot_en) begin
            pneg = s12 < s6;
            pmag = pneg ? s6 - s12 : s12 - s6;
            res.half_pot = to_result(pneg, q_mul(2 * e, pmag));
        end
        if (m_press_en)
            res.half_press = to_result(aneg, q_mul(12 * e, amag));
        res.ovf = m_sat;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [RW-1:0] got,
                                   input logic [RW-1:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, field, got, want);
        err_count++;
    endtask

    // Driver: bursts of pairs with random gaps; register writes wait for an empty pipeline.
    int gap_left = 0;
    int burst_left = 1;
    int quiet = 0;
    always @(posedge i_clk) begin : drv_proc
        logic start_n, valid_n;
        t_job j;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
            m_sigma = ONE_Q24;
            m_epsilon = ONE_Q24;
            m_shift = '0;
            m_third_law = 1'b1;
            m_pot_en = 1'b1;
            m_press_en = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SIGMA:     m_sigma = i_cfg_data;
                    CFG_EPSILON:   m_epsilon = i_cfg_data;
                    CFG_SHIFT:     m_shift = i_cfg_data;
                    CFG_THIRD_LAW: m_third_law = i_cfg_data[0];
                    CFG_POT_EN:    m_pot_en = i_cfg_data[0];
                    CFG_PRESS_EN:  m_press_en = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_q.push_back(lj_pair_force({pos_drv[8], pos_drv[7], pos_drv[6],
                    pos_drv[5], pos_drv[4], pos_drv[3], pos_drv[2], pos_drv[1], pos_drv[0]}));
            quiet = (expected_q.size() == 0) ? quiet + 1 : 0;
            if (!((start && busy) || (i_cfg_valid && !o_cfg_ready))) begin
                start_n = 1'b0;
                valid_n = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (job_q.size() > 0) begin
                    j = job_q[0];
                    case (j.kind)
                        JOB_PAIR: begin
                            start_n = 1'b1;
                            for (int i = 0; i < 9; i++)
                                pos_drv[i] <= j.pos[i];
                            void'(job_q.pop_front());
                            burst_left--;
                            if (burst_left <= 0) begin
                                burst_left = $urandom_range(1, 40);
                                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                            end
                        end
                        JOB_CFG: begin
                            if (quiet >= SETTLE_CYCLES) begin
                                valid_n = 1'b1;
                                i_cfg_index <= j.idx;
                                i_cfg_data <= j.data;
                                void'(job_q.pop_front());
                            end
                        end
                        default: begin
                            if (expected_q.size() == 0)
                                void'(job_q.pop_front());
                        end
                    endcase
                end
                start <= start_n;
                i_cfg_valid <= valid_n;
            end
        end
    end

    // Monitor: every strobed word is checked against the oldest prediction.
    always @(posedge i_clk) begin : mon_proc
        t_lj_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_q.size() == 0) begin
                $display("%0t: result word with no pair outstanding", $realtime);
                err_count++;
            end else begin
                want = expected_q.pop_front();
                if (o_force_x !== want.force_v[0])
                    report_mismatch("force_x", o_force_x, want.force_v[0]);
                if (o_force_y !== want.force_v[1])
                    report_mismatch("force_y", o_force_y, want.force_v[1]);
                if (o_force_z !== want.force_v[2])
                    report_mismatch("force_z", o_force_z, want.force_v[2]);
                if (o_half_potential !== want.half_pot)
                    report_mismatch("half_potential", o_half_potential, want.half_pot);
                if (o_half_pressure !== want.half_press)
                    report_mismatch("half_pressure", o_half_pressure, want.half_press);
                if (o_partner_applies !== want.partner)
                    report_mismatch("partner_applies", RW'(o_partner_applies), RW'(want.partner));
                if (o_overflow !== want.ovf)
                    report_mismatch("overflow", RW'(o_overflow), RW'(want.ovf));
            end
        end
    end

    task automatic add_pair(input logic [31:0] f0, f1, f2, s0, s1, s2, o0, o1, o2);
        t_job j;
        j.kind = JOB_PAIR;
        j.pos = {o2, o1, o0, s2, s1, s0, f2, f1, f0};
        j.idx = '0;
        j.data = '0;
        job_q.push_back(j);
    endtask

    task automatic add_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        t_job j;
        j.kind = JOB_CFG;
        j.pos = '0;
        j.idx = idx;
        j.data = data;
        job_q.push_back(j);
    endtask

    task automatic add_drain();
        t_job j;
        j.kind = JOB_DRAIN;
        j.pos = '0;
        j.idx = '0;
        j.data = '0;
        job_q.push_back(j);
    endtask

    // Single-bit registers get junk in the upper bits, which must be ignored.
    task automatic add_setting(input logic [31:0] sig, eps, sh, input logic tl, pe, pr);
        add_cfg(CFG_SIGMA, sig);
        add_cfg(CFG_EPSILON, eps);
        add_cfg(CFG_SHIFT, sh);
        add_cfg(CFG_THIRD_LAW, {31'($urandom() >> 1), tl});
        add_cfg(CFG_POT_EN, {31'($urandom() >> 1), pe});
        add_cfg(CFG_PRESS_EN, {31'($urandom() >> 1), pr});
    endtask

    // Mostly realistic pairs near the interaction range; some pure noise.
    task automatic add_random_pair();
        logic [31:0] f [3], s [3], o [3];
        int k;
        if ($urandom_range(0, 99) < 15) begin
            add_pair($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom());
            return;
        end
        k = $urandom_range(14, 27);
        for (int i = 0; i < 3; i++) begin
            f[i] = $urandom() >> 2;
            if ($urandom_range(0, 1)) f[i] = -f[i];
            o[i] = ($urandom_range(0, 2) == 0) ? (int'($urandom_range(0, 1 << 25)) - (1 << 24)) : 0;
            s[i] = f[i] + (int'($urandom_range(0, 1 << k)) - (1 << (k - 1))) - o[i];
        end
        add_pair(f[0], f[1], f[2], s[0], s[1], s[2], o[0], o[1], o[2]);
    endtask

    // Stimulus and end of run.
    initial begin
        // Directed pairs under the reset settings (sigma 1, epsilon 1).
        add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_pair('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, 0, 0, 0);
        add_pair(0, 0, 0, 32'h0040_0000, 0, 0, 0, 0, 0);
        add_pair(0, 0, 0, 0, 32'h0047_CFD7, 0, 0, 0, 0);
        add_pair(0, 0, 0, 0, 0, 32'h0020_0000, 0, 0, 0);
        add_pair(0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_pair(32'h0060_0000, 32'h0010_0000, 0, 0, 0, 0, 0, 0, 0);
        add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_pair(0, 0, 0, 32'h1900_0000, 0, 0, 0, 0, 0);
        add_pair(32'h0100_0000, 0, 0, 32'h0100_0000, 0, 0, 32'h0060_0000, 0, 0);
        add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'h0030_0000, 0);
        // Pressure term on, partner off, zero distance with a shift.
        add_setting(ONE_Q24, ONE_Q24, ONE_Q24 >> 2, 1'b0, 1'b1, 1'b1);
        add_cfg(CFG_SPARE_LO, $urandom());
        add_cfg(CFG_SPARE_HI, $urandom());
        add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(0, 0, 0, 32'h0040_0000, 0, 0, 0, 0, 0);
        add_pair(0, 0, 0, 0, 0, 32'hFFF0_0000, 0, 0, 0);
        add_setting('0, '0, '0, 1'b1, 1'b0, 1'b0);
        add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(0, 0, 0, 32'h0040_0000, 0, 0, 0, 0, 0);
        add_setting('1, '1, '1, 1'b0, 1'b1, 1'b1);
        add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(0, 0, 0, 32'h0040_0000, 32'h0040_0000, 0, 0, 0, 0);

        // Random phases across settings, the extremes among them.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: add_setting(ONE_Q24, ONE_Q24, '0, 1'b1, 1'b1, 1'b1);
                1: add_setting('1, '1, '0, 1'b0, 1'b0, 1'b1);
                2: add_setting('0, '0, '1, 1'b1, 1'b1, 1'b0);
                3: add_setting(ONE_Q24 >> 1, 32'h0280_0000, ONE_Q24 >> 2, 1'b0, 1'b1, 1'b1);
                4: add_setting($urandom_range(ONE_Q24 >> 1, 3 * ONE_Q24), $urandom(),
                               $urandom_range(0, ONE_Q24 >> 4), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                default: add_setting($urandom(), $urandom(), $urandom() >> $urandom_range(0, 31),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)));
            endcase
            for (int n = 0; n < 100; n++) begin
                add_random_pair();
                if (ph == 2 && n == 50)
                    add_drain();
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (job_q.size() != 0 || start || i_cfg_valid)
            @(posedge i_clk);
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog against a hung pipeline.
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
